FILE: design/led_panel_refresh_framer_unit_defines.svh
// Assertion macros shared by the framer modules.
`ifndef LED_PANEL_REFRESH_FRAMER_UNIT_DEFINES_SVH
`define LED_PANEL_REFRESH_FRAMER_UNIT_DEFINES_SVH

// Checked at every clock edge while reset is released.
`define LPRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define LPRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: design/lprf_pkg.sv
package lprf_pkg;

  // Framing bytes.
  localparam logic [7:0] CmdData  = 8'h40;
  localparam logic [7:0] CmdAddr  = 8'hC0;
  localparam logic [7:0] CmdDisp  = 8'h88;
  localparam logic [7:0] Blank    = 8'hFF;
  localparam logic [2:0] MaxLevel = 3'd6;

  // Byte positions inside one refresh.
  typedef logic [4:0] idx_t;
  localparam idx_t IdxCmd       = 5'd0;
  localparam idx_t IdxAddr      = 5'd1;
  localparam idx_t IdxPadLo     = 5'd2;
  localparam idx_t IdxPadLoEnd  = 5'd5;
  localparam idx_t IdxBar       = 5'd6;
  localparam idx_t IdxBarEnd    = 5'd9;
  localparam idx_t IdxStrength  = 5'd10;
  localparam idx_t IdxStatus    = 5'd11;
  localparam idx_t IdxPadHi     = 5'd12;
  localparam idx_t IdxPadHiEnd  = 5'd16;
  localparam idx_t IdxCtrl      = 5'd17;

  // Register indexes, selected by paddr bit 2.
  localparam logic RegDim    = 1'b0;
  localparam logic RegBright = 1'b1;

  typedef struct packed {
    logic [3:0][7:0] bar;
    logic [7:0]      strength;
    logic [7:0]      status;
    logic [7:0]      ctrl;
  } frame_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  function automatic logic [7:0] bar_byte(input logic [2:0] level, input logic probe);
    logic [2:0] sat;
    logic [6:0] ones;
    sat  = (level > MaxLevel) ? MaxLevel : level;
    ones = (7'd1 << sat) - 7'd1;
    return {probe, probe, ones[5:0]};
  endfunction

  function automatic logic [7:0] strength_byte(input logic [1:0] strength);
    logic [7:0] b;
    b = '0;
    b[{strength, 1'b0}]   = 1'b1;
    b[{strength, 1'b1}]   = 1'b1;
    return b;
  endfunction

  function automatic logic [7:0] status_byte(input logic [3:0] flags);
    logic [7:0] b;
    for (int k = 0; k < 4; k++) begin
      b[2*k]   = flags[k];
      b[2*k+1] = flags[k];
    end
    return b;
  endfunction

endpackage

FILE: design/led_panel_refresh_framer_unit.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | in_valid_i / in_stall_o   | one panel status snapshot
// out      | output    | out_valid_o / out_stall_i | one framed byte with marks
// cfg      | input     | APB psel/penable/pready   | dim_level, bright_level
//
// A refresh is 18 bytes delivered one per cycle while the output is not stalled, from a registered output.
// The front takes a snapshot whenever the queue is not full. The two-entry frame queue
// holds the frame being sent plus one more, so one further refreshing snapshot can be
// taken meanwhile. Snapshots that cause no refresh stall on a full queue too.
// Reset restores the kept snapshot to zero and marks the next snapshot to refresh.
// Output stall holds the byte register; the front stalls only on a full queue.
module led_panel_refresh_framer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  strength_i,
  input  logic [3:0]  probe_flags_i,
  input  logic [2:0]  level_a_i,
  input  logic [2:0]  level_b_i,
  input  logic [2:0]  level_c_i,
  input  logic [2:0]  level_d_i,
  input  logic [3:0]  status_flags_i,
  input  logic        force_refresh_i,
  input  logic        standby_expired_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        start_before_o,
  output logic        stop_after_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]       dim_q, bright_q;
  logic             q_full, q_valid, pop;
  lprf_pkg::qctl_t  qctl;
  lprf_pkg::frame_t wframe, rframe;

  assign pready = 1'b1;
  assign prdata = {29'd0, (paddr[2] == lprf_pkg::RegBright) ? bright_q : dim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= 3'd2;
      bright_q <= 3'd7;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == lprf_pkg::RegBright) begin
        bright_q <= pwdata[2:0];
      end else begin
        dim_q <= pwdata[2:0];
      end
    end
  end

  lprf_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .strength_i,
    .probe_flags_i,
    .level_a_i,
    .level_b_i,
    .level_c_i,
    .level_d_i,
    .status_flags_i,
    .force_refresh_i,
    .standby_expired_i,
    .dim_level_i    (dim_q),
    .bright_level_i (bright_q),
    .q_full_i       (q_full),
    .qctl_o         (qctl),
    .frame_o        (wframe)
  );

  lprf_queue u_queue (
    .clk_i,
    .rst_ni,
    .qctl_i  (qctl),
    .wdata_i (wframe),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rdata_o (rframe)
  );

  lprf_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .frame_i   (rframe),
    .pop_o     (pop),
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .start_before_o,
    .stop_after_o,
    .last_o
  );

endmodule

FILE: design/lprf_front.sv
module lprf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           strength_i,
  input  logic [3:0]           probe_flags_i,
  input  logic [2:0]           level_a_i,
  input  logic [2:0]           level_b_i,
  input  logic [2:0]           level_c_i,
  input  logic [2:0]           level_d_i,
  input  logic [3:0]           status_flags_i,
  input  logic                 force_refresh_i,
  input  logic                 standby_expired_i,
  input  logic [2:0]           dim_level_i,
  input  logic [2:0]           bright_level_i,
  input  logic                 q_full_i,
  output lprf_pkg::qctl_t      qctl_o,
  output lprf_pkg::frame_t     frame_o
);

  logic [1:0]       strength_q;
  logic [3:0]       probes_q;
  logic [3:0][2:0]  levels_q;
  logic [3:0][2:0]  levels;
  logic [3:0]       status_q;
  logic             pending_q;
  logic             accept;
  logic             changed;

  assign levels = {level_d_i, level_c_i, level_b_i, level_a_i};
  assign accept = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  assign changed = (strength_i != strength_q) || (probe_flags_i != probes_q) ||
                   (levels != levels_q) || (status_flags_i != status_q);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      frame_o.bar[k] = lprf_pkg::bar_byte(levels[k], probe_flags_i[k]);
    end
    frame_o.strength = lprf_pkg::strength_byte(strength_i);
    frame_o.status   = lprf_pkg::status_byte(status_flags_i);
    frame_o.ctrl     = lprf_pkg::CmdDisp |
                       {5'd0, standby_expired_i ? dim_level_i : bright_level_i};
  end

  assign qctl_o.push = accept && (changed || force_refresh_i || pending_q);
  assign qctl_o.full = q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= '0;
      probes_q   <= '0;
      levels_q   <= '0;
      status_q   <= '0;
      pending_q  <= 1'b1;
    end else if (accept) begin
      strength_q <= strength_i;
      probes_q   <= probe_flags_i;
      levels_q   <= levels;
      status_q   <= status_flags_i;
      pending_q  <= 1'b0;
    end
  end

endmodule

FILE: design/lprf_queue.sv
`include "led_panel_refresh_framer_unit_defines.svh"

module lprf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lprf_pkg::qctl_t  qctl_i,
  input  lprf_pkg::frame_t wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output lprf_pkg::frame_t rdata_o
);

  lprf_pkg::frame_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push;

  assign push    = qctl_i.push && !full_o;
  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop_i && valid_o) rptr_q <= !rptr_q;
      count_q <= count_q + 2'(push) - 2'(pop_i && valid_o);
    end
  end

  `LPRF_ASSERT_ALWAYS(a_count_bound, count_q != 2'd3, "queue count out of range")
  `LPRF_ASSERT(a_no_push_full, qctl_i.push |-> !qctl_i.full, "push while full")
  `LPRF_ASSERT(a_no_pop_empty, pop_i |-> valid_o, "pop while empty")

endmodule

FILE: design/lprf_back.sv
`include "led_panel_refresh_framer_unit_defines.svh"

module lprf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  lprf_pkg::frame_t frame_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             start_before_o,
  output logic             stop_after_o,
  output logic             last_o
);

  lprf_pkg::idx_t idx_q, idx_d;
  logic       valid_q;
  logic       load;
  logic [7:0] byte_d;
  logic       start_d, stop_d, last_d;
  logic [1:0] bar_sel;

  assign load    = q_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && (idx_q == lprf_pkg::IdxCtrl);
  assign idx_d   = pop_o ? lprf_pkg::IdxCmd : idx_q + 5'd1;
  assign bar_sel = 2'(idx_q - lprf_pkg::IdxBar);

  always_comb begin
    byte_d  = lprf_pkg::Blank;
    start_d = 1'b0;
    stop_d  = 1'b0;
    last_d  = 1'b0;
    unique case (idx_q) inside
      lprf_pkg::IdxCmd: begin
        byte_d  = lprf_pkg::CmdData;
        start_d = 1'b1;
        stop_d  = 1'b1;
      end
      lprf_pkg::IdxAddr: begin
        byte_d  = lprf_pkg::CmdAddr;
        start_d = 1'b1;
      end
      [lprf_pkg::IdxPadLo:lprf_pkg::IdxPadLoEnd]: byte_d = lprf_pkg::Blank;
      [lprf_pkg::IdxBar:lprf_pkg::IdxBarEnd]:     byte_d = frame_i.bar[bar_sel];
      lprf_pkg::IdxStrength:                      byte_d = frame_i.strength;
      lprf_pkg::IdxStatus:                        byte_d = frame_i.status;
      [lprf_pkg::IdxPadHi:lprf_pkg::IdxPadHiEnd]: begin
        byte_d = lprf_pkg::Blank;
        stop_d = (idx_q == lprf_pkg::IdxPadHiEnd);
      end
      lprf_pkg::IdxCtrl: begin
        byte_d  = frame_i.ctrl;
        start_d = 1'b1;
        stop_d  = 1'b1;
        last_d  = 1'b1;
      end
      default: byte_d = lprf_pkg::Blank;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= lprf_pkg::IdxCmd;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_d;
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o     <= byte_d;
      start_before_o <= start_d;
      stop_after_o   <= stop_d;
      last_o         <= last_d;
    end
  end

  assign out_valid_o = valid_q;

  `LPRF_ASSERT_ALWAYS(a_idx_range, idx_q <= lprf_pkg::IdxCtrl, "byte index out of range")
  `LPRF_ASSERT(a_wrap, pop_o |=> idx_q == lprf_pkg::IdxCmd, "index did not wrap after frame")
  `LPRF_ASSERT(a_last_framing, valid_q && last_o |-> start_before_o && stop_after_o,
               "last byte lacks framing")

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CycleLimit   = 400000;
  localparam int          SettleCycles = 24;
  localparam logic [7:0]  ProbeMask    = 8'hC0;
  localparam logic [7:0]  PairLow      = 8'h03;
  localparam logic [7:0]  SegMask      = 8'h3F;

  typedef struct packed {
    logic [1:0]      strength;
    logic [3:0]      probes;
    logic [3:0][2:0] levels;
    logic [3:0]      status;
    logic            force_on;
    logic            standby;
  } snap_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start_b;
    logic       stop_a;
    logic       last_b;
  } frame_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  snap_t       in_snap     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        start_before_o;
  logic        stop_after_o;
  logic        last_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state: the kept snapshot and the brightness registers.
  snap_t       kept_snap;
  logic        powerup_pending;
  logic [2:0]  cfg_dim;
  logic [2:0]  cfg_bright;

  snap_t       snap_pending_q[$];
  frame_byte_t frame_q[$];
  frame_byte_t want_byte;
  snap_t       gen_last;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          err_count      = 0;
  int          cycle_cnt      = 0;

  led_panel_refresh_framer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .strength_i       (in_snap.strength),
    .probe_flags_i    (in_snap.probes),
    .level_a_i        (in_snap.levels[0]),
    .level_b_i        (in_snap.levels[1]),
    .level_c_i        (in_snap.levels[2]),
    .level_d_i        (in_snap.levels[3]),
    .status_flags_i   (in_snap.status),
    .force_refresh_i  (in_snap.force_on),
    .standby_expired_i(in_snap.standby),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .start_before_o   (start_before_o),
    .stop_after_o     (stop_after_o),
    .last_o           (last_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at cycle %0d: %s got %02h expected %02h", cycle_cnt, what, got, want);
    err_count++;
  endtask

  function automatic void push_frame_byte(input logic [7:0] data, input logic st,
                                          input logic sp, input logic lst);
    frame_q.push_back(frame_byte_t'{data, st, sp, lst});
  endfunction

  function automatic void predict_refresh(input snap_t s);
    logic       changed;
    logic [2:0] seg;
    logic [7:0] b;
    changed = (s.strength != kept_snap.strength) || (s.probes != kept_snap.probes) ||
              (s.levels != kept_snap.levels) || (s.status != kept_snap.status) ||
              s.force_on || powerup_pending;
    kept_snap       = s;
    powerup_pending = 1'b0;
    if (!changed) return;

    push_frame_byte(lprf_pkg::CmdData, 1'b1, 1'b1, 1'b0);
    push_frame_byte(lprf_pkg::CmdAddr, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) push_frame_byte(lprf_pkg::Blank, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      seg = (s.levels[i] > lprf_pkg::MaxLevel) ? lprf_pkg::MaxLevel : s.levels[i];
      b   = ((8'd1 << seg) - 8'd1) & SegMask;
      if (s.probes[i]) b = b | ProbeMask;
      push_frame_byte(b, 1'b0, 1'b0, 1'b0);
    end
    push_frame_byte(PairLow << {s.strength, 1'b0}, 1'b0, 1'b0, 1'b0);
    b = '0;
    for (int i = 0; i < 4; i++) b[2*i +: 2] = {2{s.status[i]}};
    push_frame_byte(b, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) push_frame_byte(lprf_pkg::Blank, 1'b0, i == 4, 1'b0);
    push_frame_byte(lprf_pkg::CmdDisp | {5'd0, s.standby ? cfg_dim : cfg_bright},
                    1'b1, 1'b1, 1'b1);
  endfunction

  // Request driver: a new snapshot goes out only once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_refresh(in_snap);
      if (!in_valid_i || !in_stall_o) begin
        if (snap_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_snap    <= snap_pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_snap    <= snap_t'($urandom);
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_q.size() == 0) begin
          report_mismatch("unexpected byte", out_byte_o, 8'h00);
        end else begin
          want_byte = frame_q.pop_front();
          if (out_byte_o !== want_byte.data)
            report_mismatch("out_byte", out_byte_o, want_byte.data);
          if (start_before_o !== want_byte.start_b)
            report_mismatch("start_before", {7'd0, start_before_o},
                            {7'd0, want_byte.start_b});
          if (stop_after_o !== want_byte.stop_a)
            report_mismatch("stop_after", {7'd0, stop_after_o}, {7'd0, want_byte.stop_a});
          if (last_o !== want_byte.last_b)
            report_mismatch("last", {7'd0, last_o}, {7'd0, want_byte.last_b});
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout with %0d bytes still expected", frame_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic snap_t mk(input int str, input int pr, input int la, input int lb,
                               input int lc, input int ld, input int st, input int fo,
                               input int sb);
    snap_t s;
    s.strength  = 2'(str);
    s.probes    = 4'(pr);
    s.levels[0] = 3'(la);
    s.levels[1] = 3'(lb);
    s.levels[2] = 3'(lc);
    s.levels[3] = 3'(ld);
    s.status    = 4'(st);
    s.force_on  = 1'(fo);
    s.standby   = 1'(sb);
    return s;
  endfunction

  // Mostly repeats and small edits of the last snapshot, so that both the
  // refresh and the no-refresh paths are taken often.
  function automatic snap_t vary_snapshot(input snap_t base);
    snap_t s;
    int    r;
    s          = base;
    s.force_on = 1'b0;
    s.standby  = 1'($urandom_range(1));
    r          = $urandom_range(99);
    if (r >= 30 && r < 45) begin
      s.force_on = 1'b1;
    end else if (r >= 45 && r < 70) begin
      case ($urandom_range(3))
        0: s.strength = 2'($urandom);
        1: s.probes = 4'($urandom);
        2: s.levels[2'($urandom_range(3))] = 3'($urandom);
        default: s.status = 4'($urandom);
      endcase
    end else if (r >= 70) begin
      s          = snap_t'($urandom);
      s.force_on = ($urandom_range(3) == 0);
    end
    return s;
  endfunction

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) begin
      gen_last = vary_snapshot(gen_last);
      snap_pending_q.push_back(gen_last);
    end
  endtask

  // Sampled at the falling edge so that the driver's updates have settled.
  task automatic wait_drained();
    while (snap_pending_q.size() != 0 || in_valid_i || frame_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic idx, input logic [2:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~32'h7) | {29'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == lprf_pkg::RegDim) cfg_dim = val;
    else cfg_bright = val;
  endtask

  initial begin
    kept_snap       = '0;
    powerup_pending = 1'b1;
    cfg_dim         = 3'd2;
    cfg_bright      = 3'd7;
    rst_ni          = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset brightness values.
    snap_pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    snap_pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
    snap_pending_q.push_back(mk(0, 0, 0, 0, 0, 0, 0, 1, 0));
    snap_pending_q.push_back(mk(3, 15, 7, 7, 7, 7, 15, 0, 1));
    snap_pending_q.push_back(mk(3, 15, 6, 6, 6, 6, 15, 0, 1));
    snap_pending_q.push_back(mk(3, 15, 6, 6, 6, 6, 15, 0, 0));
    snap_pending_q.push_back(mk(3, 15, 6, 6, 6, 6, 15, 1, 0));
    snap_pending_q.push_back(mk(1, 1, 1, 2, 3, 4, 1, 0, 0));
    snap_pending_q.push_back(mk(2, 2, 5, 0, 1, 6, 2, 0, 1));
    snap_pending_q.push_back(mk(0, 4, 2, 3, 4, 5, 4, 0, 0));
    snap_pending_q.push_back(mk(3, 8, 0, 7, 0, 7, 8, 0, 1));
    snap_pending_q.push_back(mk(3, 8, 0, 7, 0, 7, 8, 0, 1));
    snap_pending_q.push_back(mk(1, 0, 7, 0, 7, 0, 0, 0, 0));
    snap_pending_q.push_back(mk(1, 0, 7, 0, 7, 0, 0, 1, 1));
    snap_pending_q.push_back(mk(2, 5, 3, 3, 3, 3, 10, 0, 0));
    gen_last = mk(0, 10, 4, 4, 4, 4, 5, 0, 1);
    snap_pending_q.push_back(gen_last);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          apb_write(lprf_pkg::RegDim, 3'd0);
          apb_write(lprf_pkg::RegBright, 3'd0);
        end
        1: begin
          send_idle_pct  = 50;
          recv_stall_pct = 0;
          apb_write(lprf_pkg::RegDim, 3'd7);
          apb_write(lprf_pkg::RegBright, 3'd7);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 50;
          apb_write(lprf_pkg::RegDim, 3'd7);
          apb_write(lprf_pkg::RegBright, 3'd0);
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
          apb_write(lprf_pkg::RegDim, 3'($urandom));
          apb_write(lprf_pkg::RegBright, 3'($urandom));
        end
      endcase
      // The sender holds off mid-phase until the block has emptied out.
      push_random(40);
      wait_drained();
      push_random(61);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
